[hw/rtl/fvf_pkg.sv]
package fvf_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int VALUE_W     = 32;
    localparam int K_W         = 7;
    localparam int K_MAX       = 64;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIVC_W      = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified element on its way from the front to the back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               wr;
        logic [ADDR_W-1:0]  addr;
        logic               last;
        logic [CNT_W-1:0]   n;
        logic               ovf;
    } t_cmd;

endpackage

[hw/rtl/fvf_in_if.sv]
interface fvf_in_if;
    import fvf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink (input valid, input value, input is_last, output ready);
endinterface

[hw/rtl/fvf_out_if.sv]
interface fvf_out_if;
    import fvf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic                      found;
    logic                      overflow;
    logic                      last_result;

    modport source (output valid, output result_value, output found, output overflow,
                    output last_result, input ready);
    modport sink (input valid, input result_value, input found, input overflow,
                  input last_result, output ready);
endinterface

[hw/rtl/frequent_value_finder_core.sv]
// Takes one word a cycle (value, is_last) while the 4-deep queue has room; words are
// written to a 1024-entry element memory and the word with is_last closes the run. The
// search then finds the threshold floor(n/k) for a run of n elements by restoring
// division and, for each stored element i, compares it against the whole store through
// the single read port of the element memory, stopping early when i repeats an earlier
// value; the search can also wait on the result side. Words of the next run are taken
// meanwhile until the queue is full. Results come out in order of first appearance, the
// final one marked with last_result; with no match a single word with found low closes
// the run. Words beyond 1024 are dropped and flag overflow on every result of that run.
// divisor_k (reset 1; 0 acts as 1, above 64 acts as 64) must be written only while the
// block is idle; the block itself does not enforce this.
module frequent_value_finder_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fvf_in_if.sink                  i_in,
    fvf_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [fvf_pkg::K_W-1:0] i_cfg_data
);
    import fvf_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_push;
    logic q_ready;
    logic q_valid;
    logic back_pop;

    fvf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_cmd     (front_cmd),
        .o_push    (front_push),
        .i_q_ready (q_ready)
    );

    fvf_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (back_pop)
    );

    fvf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (back_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );
endmodule

[hw/rtl/fvf_ram.sv]
module fvf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/fvf_front.sv]
module fvf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fvf_in_if.sink        i_in,
    output fvf_pkg::t_cmd o_cmd,
    output logic          o_push,
    input  logic          i_q_ready
);
    import fvf_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    logic             accept;
    logic             room;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign room       = r_count < CNT_W'(STORE_DEPTH);

    always_comb begin
        o_cmd.value = i_in.value;
        o_cmd.wr    = room;
        o_cmd.addr  = r_count[ADDR_W-1:0];
        o_cmd.last  = i_in.is_last;
        o_cmd.n     = room ? r_count + CNT_W'(1) : r_count;
        o_cmd.ovf   = r_ovf || !room;
        o_push      = 1'b0;
        n_count     = r_count;
        n_ovf       = r_ovf;
        if (accept) begin
            // a dropped word that does not close the run needs no slot in the queue
            o_push = room || i_in.is_last;
            if (i_in.is_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = o_cmd.n;
                n_ovf   = o_cmd.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end
endmodule

[hw/rtl/fvf_fifo.sv]
module fvf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fvf_pkg::t_cmd i_data,
    output logic          o_ready,
    output logic          o_valid,
    output fvf_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import fvf_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_ready = r_fill != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - (QPTR_W + 1)'(1);
            end
        end
    end
endmodule

[hw/rtl/fvf_back.sv]
module fvf_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  fvf_pkg::t_cmd           i_cmd,
    output logic                    o_pop,
    input  logic                    i_cfg_we,
    input  logic [fvf_pkg::K_W-1:0] i_cfg_data,
    fvf_out_if.source               o_out
);
    import fvf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_RDX  = 8'b0000_0100,
        S_LDX  = 8'b0000_1000,
        S_SCAN = 8'b0001_0000,
        S_EVAL = 8'b0010_0000,
        S_NEXT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [K_W-1:0]     r_div_k;
    logic [K_W-1:0]     r_k, n_k;
    logic [K_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]   r_quo, n_quo;
    logic [DIVC_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_ovf, n_ovf;
    logic [ADDR_W-1:0]  r_i, n_i;
    logic [ADDR_W-1:0]  r_jd, n_jd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_x, n_x;
    logic [VALUE_W-1:0] r_pend, n_pend;
    logic               r_pend_vld, n_pend_vld;
    logic               r_out_vld, n_out_vld;
    logic [VALUE_W-1:0] r_out_val, n_out_val;
    logic               r_out_found, n_out_found;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;
    logic [ADDR_W-1:0]  raddr;
    logic [VALUE_W-1:0] rdata;
    logic               ram_we;
    logic               out_busy;

    assign out_busy           = r_out_vld && !o_out.ready;
    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_out_val;
    assign o_out.found        = r_out_found;
    assign o_out.overflow     = r_out_ovf;
    assign o_out.last_result  = r_out_last;
    assign o_pop              = r_state == S_IDLE;
    assign ram_we             = (r_state == S_IDLE) && i_cmd_valid && i_cmd.wr;

    fvf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [K_W-1:0] rem_sh;
        logic           ge;
        logic           eq;

        rem_sh      = {r_rem[K_W-2:0], r_quo[CNT_W-1]};
        ge          = rem_sh >= r_k;
        eq          = rdata == r_x;
        n_state     = r_state;
        n_k         = r_k;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_jd        = r_jd;
        n_cnt       = r_cnt;
        n_x         = r_x;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_val   = r_out_val;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        raddr       = r_i;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.last) begin
                    n_n    = i_cmd.n;
                    n_ovf  = i_cmd.ovf;
                    n_quo  = i_cmd.n;
                    n_rem  = '0;
                    n_step = DIVC_W'(CNT_W - 1);
                    if (r_div_k == '0) begin
                        n_k = K_W'(1);
                    end else if (r_div_k > K_W'(K_MAX)) begin
                        n_k = K_W'(K_MAX);
                    end else begin
                        n_k = r_div_k;
                    end
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle; quotient is the threshold
                n_rem = ge ? rem_sh - r_k : rem_sh;
                n_quo = CNT_W'({r_quo, ge});
                n_step = r_step - DIVC_W'(1);
                if (r_step == '0) begin
                    n_i     = '0;
                    n_state = S_RDX;
                end
            end
            S_RDX: begin
                raddr   = r_i;
                n_state = S_LDX;
            end
            S_LDX: begin
                n_x     = rdata;
                raddr   = '0;
                n_jd    = '0;
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                raddr = r_jd + ADDR_W'(1);
                n_jd  = r_jd + ADDR_W'(1);
                if (eq) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (eq && (r_jd < r_i)) begin
                    // seen earlier, so already judged
                    n_state = S_NEXT;
                end else if (CNT_W'(r_jd) + CNT_W'(1) == r_n) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cnt > r_quo) begin
                    if (!(r_pend_vld && out_busy)) begin
                        if (r_pend_vld) begin
                            n_out_vld   = 1'b1;
                            n_out_val   = r_pend;
                            n_out_found = 1'b1;
                            n_out_ovf   = r_ovf;
                            n_out_last  = 1'b0;
                        end
                        n_pend     = r_x;
                        n_pend_vld = 1'b1;
                        n_state    = S_NEXT;
                    end
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_i = r_i + ADDR_W'(1);
                if (CNT_W'(r_i) + CNT_W'(1) == r_n) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RDX;
                end
            end
            S_FIN: begin
                if (!out_busy) begin
                    n_out_vld   = 1'b1;
                    n_out_val   = r_pend_vld ? r_pend : '0;
                    n_out_found = r_pend_vld;
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b1;
                    n_pend_vld  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_div_k    <= K_W'(1);
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_div_k <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_n         <= n_n;
        r_ovf       <= n_ovf;
        r_i         <= n_i;
        r_jd        <= n_jd;
        r_cnt       <= n_cnt;
        r_x         <= n_x;
        r_pend      <= n_pend;
        r_out_val   <= n_out_val;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end
endmodule
